FILE: sv/chb_pkg.sv
`default_nettype none
package chb_pkg;

    localparam int MAX_COEFFS = 32;
    localparam int COEF_AW    = $clog2(MAX_COEFFS);

    localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT_MIN = 64'h8000_0000_0000_0000;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_ZERO_RADIUS = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW    = 2'd2;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_DS_GO, S_DS_WAIT, S_IW_GO, S_IW_WAIT, S_ID_GO, S_ID_WAIT,
        S_FV_GO, S_FV_WAIT, S_FN_GO, S_FN_WAIT, S_DL_GO, S_DL_WAIT, S_OUT
    } t_state;

    typedef struct packed {
        logic [63:0] value;
        logic        ovf;
    } t_arith_res;

    // {overflow, result}
    function automatic logic [64:0] sat_add(logic [63:0] a, logic [63:0] b);
        logic [63:0] r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63]) begin
            return {1'b1, (a[63] ? SAT_MIN : SAT_MAX)};
        end
        return {1'b0, r};
    endfunction

    function automatic logic [64:0] sat_sub(logic [63:0] a, logic [63:0] b);
        logic [63:0] r;
        r = a - b;
        if (a[63] != b[63] && r[63] != a[63]) begin
            return {1'b1, (a[63] ? SAT_MIN : SAT_MAX)};
        end
        return {1'b0, r};
    endfunction

    function automatic logic [63:0] mag_of(logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

endpackage
`default_nettype wire

FILE: sv/chb_if.sv
`default_nettype none
interface chb_item_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [4:0]  coef_index;
    logic [63:0] coef_value;
    logic [63:0] time_point;
    logic [63:0] midpoint;
    logic [62:0] radius;
    modport source (output valid, func, coef_index, coef_value, time_point, midpoint, radius,
                    input ready);
    modport sink   (input valid, func, coef_index, coef_value, time_point, midpoint, radius,
                    output ready);
endinterface

interface chb_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic [63:0] slope;
    logic [1:0]  status;
    modport source (output valid, value, slope, status, input ready);
    modport sink   (input valid, value, slope, status, output ready);
endinterface
`default_nettype wire

FILE: sv/chebyshev_eval_with_derivative.sv
// A load writes the store on acceptance; an evaluate runs two 128-step restoring divisions
// and a shared multiplier used twice a term before its result reaches the output register.
// One item at a time; loads go back to back, and an evaluate holds off the next item, which
// is taken once the result sits in the output register.
// A zero radius skips the divisions and the multiplier and goes straight to the output state.
// Reset (synchronous, active low) clears control state and degree; the store is not cleared.
`default_nettype none
module chebyshev_eval_with_derivative (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [4:0] i_cfg_wr_data,
    chb_item_if.sink        i_item,
    chb_res_if.source       o_res
);
    import chb_pkg::*;

    t_state       r_state, n_state;
    logic [4:0]   r_degree;
    logic [63:0]  r_x, r_m, r_mag, r_s, r_num;
    logic [62:0]  r_r;
    logic         r_neg, r_ovf;
    logic [4:0]   r_j;
    logic [63:0]  r_w0, r_w1, r_w2, r_d0, r_d1, r_d2;
    logic [63:0]  r_val, r_slp;
    logic [1:0]   r_stat;
    logic         r_out_valid;
    logic [63:0]  r_out_value, r_out_slope;
    logic [1:0]   r_out_status;

    logic         accept, out_free;
    logic         mul_start, mul_sh61, mul_done;
    logic [63:0]  mul_b;
    t_arith_res   mul_res;
    logic         div_start, div_sh61, div_done, div_neg;
    logic [63:0]  div_mag;
    t_arith_res   div_res;
    logic         ram_we, ram_re;
    logic [31:0]  widx_ext, ridx_ext;
    logic [COEF_AW-1:0] ram_waddr, ram_raddr;
    logic [63:0]  ram_rdata;
    logic [4:0]   deg_clamp;
    logic [64:0]  sum_a, sum_b, sum_c;

    assign accept   = i_item.valid && i_item.ready;
    assign out_free = !r_out_valid || o_res.ready;
    assign deg_clamp = (32'(r_degree) > 32'(MAX_COEFFS - 1)) ? 5'(MAX_COEFFS - 1) : r_degree;

    assign widx_ext  = 32'(i_item.coef_index);
    assign ram_waddr = widx_ext[COEF_AW-1:0];
    assign ram_we    = accept && (i_item.func == FUNC_LOAD) && (widx_ext < 32'(MAX_COEFFS));
    assign ridx_ext  = (r_state == S_FV_GO) ? 32'd0 : 32'(r_j);
    assign ram_raddr = ridx_ext[COEF_AW-1:0];
    assign ram_re    = (r_state == S_IW_GO) || (r_state == S_FV_GO);

    chb_ram #(.WIDTH(64), .DEPTH(MAX_COEFFS)) u_store (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(i_item.coef_value),
        .i_re(ram_re), .i_raddr(ram_raddr), .o_rdata(ram_rdata)
    );

    chb_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start), .i_a(r_s), .i_b(mul_b),
        .i_sh61(mul_sh61), .o_done(mul_done), .o_res(mul_res)
    );

    chb_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start), .i_mag(div_mag),
        .i_neg(div_neg), .i_sh61(div_sh61), .i_r(r_r), .o_done(div_done), .o_res(div_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_degree    <= 5'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_degree <= i_cfg_wr_data;
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        i_item.ready = 1'b0;
        mul_start = 1'b0;
        mul_sh61  = 1'b0;
        mul_b     = r_w0;
        div_start = 1'b0;
        div_sh61  = 1'b1;
        div_mag   = r_mag;
        div_neg   = r_neg;
        case (r_state)
            S_IDLE: begin
                // hold off beats while reset is applied
                i_item.ready = i_rst_n;
                if (i_item.valid && i_item.func == FUNC_EVAL) begin
                    n_state = S_PREP;
                end
            end
            S_PREP:    n_state = (r_r == '0) ? S_OUT : S_DS_GO;
            S_DS_GO: begin
                div_start = 1'b1;
                n_state   = S_DS_WAIT;
            end
            S_DS_WAIT: if (div_done) begin
                n_state = (deg_clamp == 5'd0) ? S_FV_GO : S_IW_GO;
            end
            S_IW_GO: begin
                mul_start = 1'b1;
                n_state   = S_IW_WAIT;
            end
            S_IW_WAIT: if (mul_done) begin
                n_state = S_ID_GO;
            end
            S_ID_GO: begin
                mul_start = 1'b1;
                mul_b     = r_d1;
                n_state   = S_ID_WAIT;
            end
            S_ID_WAIT: if (mul_done) begin
                n_state = (r_j == 5'd1) ? S_FV_GO : S_IW_GO;
            end
            S_FV_GO: begin
                mul_start = 1'b1;
                mul_sh61  = 1'b1;
                n_state   = S_FV_WAIT;
            end
            S_FV_WAIT: if (mul_done) begin
                n_state = S_FN_GO;
            end
            S_FN_GO: begin
                mul_start = 1'b1;
                mul_sh61  = 1'b1;
                mul_b     = r_d0;
                n_state   = S_FN_WAIT;
            end
            S_FN_WAIT: if (mul_done) begin
                n_state = S_DL_GO;
            end
            S_DL_GO: begin
                div_start = 1'b1;
                div_sh61  = 1'b0;
                div_mag   = mag_of(r_num);
                div_neg   = r_num[63];
                n_state   = S_DL_WAIT;
            end
            S_DL_WAIT: if (div_done) begin
                n_state = S_OUT;
            end
            S_OUT: if (out_free) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // recurrence arithmetic on the unit results
    always_comb begin
        sum_a = '0;
        sum_b = '0;
        sum_c = '0;
        case (r_state)
            S_IW_WAIT, S_FV_WAIT: begin
                sum_a = sat_sub(mul_res.value, (r_state == S_IW_WAIT) ? r_w2 : r_w1);
                sum_b = sat_add(ram_rdata, sum_a[63:0]);
            end
            S_ID_WAIT: begin
                sum_a = sat_add(r_w1, r_w1);
                sum_b = sat_add(sum_a[63:0], mul_res.value);
                sum_c = sat_sub(sum_b[63:0], r_d2);
            end
            S_FN_WAIT: begin
                sum_a = sat_add(r_w0, mul_res.value);
                sum_b = sat_sub(sum_a[63:0], r_d1);
            end
            default: sum_a = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: if (accept) begin
                r_x <= i_item.time_point;
                r_m <= i_item.midpoint;
                r_r <= i_item.radius;
            end
            S_PREP: begin
                r_ovf <= 1'b0;
                r_j   <= deg_clamp;
                r_w0  <= '0;
                r_w1  <= '0;
                r_d0  <= '0;
                r_d1  <= '0;
                r_val <= '0;
                r_slp <= '0;
                r_stat <= STATUS_ZERO_RADIUS;
                if ($signed(r_x) >= $signed(r_m)) begin
                    r_mag <= r_x - r_m;
                    r_neg <= 1'b0;
                end else begin
                    r_mag <= r_m - r_x;
                    r_neg <= 1'b1;
                end
            end
            S_DS_WAIT: if (div_done) begin
                r_s   <= div_res.value;
                r_ovf <= r_ovf | div_res.ovf;
            end
            S_IW_GO: begin
                r_w2 <= r_w1;
                r_w1 <= r_w0;
                r_d2 <= r_d1;
                r_d1 <= r_d0;
            end
            S_IW_WAIT: if (mul_done) begin
                r_w0  <= sum_b[63:0];
                r_ovf <= r_ovf | mul_res.ovf | sum_a[64] | sum_b[64];
            end
            S_ID_WAIT: if (mul_done) begin
                r_d0  <= sum_c[63:0];
                r_j   <= r_j - 5'd1;
                r_ovf <= r_ovf | mul_res.ovf | sum_a[64] | sum_b[64] | sum_c[64];
            end
            S_FV_WAIT: if (mul_done) begin
                r_val <= sum_b[63:0];
                r_ovf <= r_ovf | mul_res.ovf | sum_a[64] | sum_b[64];
            end
            S_FN_WAIT: if (mul_done) begin
                r_num <= sum_b[63:0];
                r_ovf <= r_ovf | mul_res.ovf | sum_a[64] | sum_b[64];
            end
            S_DL_WAIT: if (div_done) begin
                r_slp  <= div_res.value;
                r_stat <= (r_ovf | div_res.ovf) ? STATUS_OVERFLOW : STATUS_OK;
            end
            default: r_j <= r_j;
        endcase
        if (r_state == S_OUT && out_free) begin
            r_out_value  <= r_val;
            r_out_slope  <= r_slp;
            r_out_status <= r_stat;
        end
    end

    assign o_res.valid  = r_out_valid;
    assign o_res.value  = r_out_value;
    assign o_res.slope  = r_out_slope;
    assign o_res.status = r_out_status;

`ifndef SYNTHESIS
    a_zero_radius_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PREP && r_r == '0) |=> (r_state == S_OUT))
        else $error("zero radius did not go straight to output");
    a_mul_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_IW_WAIT || r_state == S_ID_WAIT ||
                      r_state == S_FV_WAIT || r_state == S_FN_WAIT))
        else $error("multiplier finished outside a wait state");
    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DS_WAIT || r_state == S_DL_WAIT))
        else $error("divider finished outside a wait state");
    a_term_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IW_GO) |-> (r_j != 5'd0 && r_j <= deg_clamp))
        else $error("term index out of range");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.status != 2'd3))
        else $error("undefined status code");
`endif
endmodule
`default_nettype wire

FILE: sv/chb_ram.sv
`default_nettype none
module chb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

FILE: sv/chb_mul.sv
`default_nettype none
module chb_mul (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [63:0]        i_a,
    input  wire logic [63:0]        i_b,
    input  wire logic               i_sh61,
    output logic                    o_done,
    output chb_pkg::t_arith_res     o_res
);
    import chb_pkg::*;

    logic         r_busy;
    logic [2:0]   r_step;
    logic [63:0]  r_ma, r_mb;
    logic         r_neg, r_sh61;
    logic [127:0] r_acc;
    logic [31:0]  a_half, b_half;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic         hi_ok;

    // steps 0..3 accumulate 32x32 partial products, 4 applies sign, 5 rounds, 6 done
    always_comb begin
        a_half = r_step[1] ? r_ma[63:32] : r_ma[31:0];
        b_half = r_step[0] ? r_mb[63:32] : r_mb[31:0];
        pp     = a_half * b_half;
        case (r_step[1:0])
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 3'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= 3'd0;
        end else if (r_busy) begin
            r_step <= r_step + 3'd1;
            if (r_step == 3'd6) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ma   <= mag_of(i_a);
            r_mb   <= mag_of(i_b);
            r_neg  <= i_a[63] ^ i_b[63];
            r_sh61 <= i_sh61;
            r_acc  <= '0;
        end else if (r_busy) begin
            case (r_step)
                3'd0, 3'd1, 3'd2, 3'd3: r_acc <= r_acc + pp_sh;
                3'd4: if (r_neg) begin
                    r_acc <= 128'd0 - r_acc;
                end
                3'd5: r_acc <= r_acc + (r_sh61 ? (128'd1 << 60) : (128'd1 << 59));
                default: r_acc <= r_acc;
            endcase
        end
    end

    always_comb begin
        if (r_sh61) begin
            hi_ok = (r_acc[127:124] == 4'h0) || (r_acc[127:124] == 4'hF);
            o_res.value = r_acc[124:61];
        end else begin
            hi_ok = (r_acc[127:123] == 5'h00) || (r_acc[127:123] == 5'h1F);
            o_res.value = r_acc[123:60];
        end
        o_res.ovf = !hi_ok;
        if (!hi_ok) begin
            o_res.value = r_acc[127] ? SAT_MIN : SAT_MAX;
        end
        o_done = r_busy && (r_step == 3'd6);
    end
endmodule
`default_nettype wire

FILE: sv/chb_div.sv
`default_nettype none
module chb_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [63:0]        i_mag,
    input  wire logic               i_neg,
    input  wire logic               i_sh61,
    input  wire logic [62:0]        i_r,
    output logic                    o_done,
    output chb_pkg::t_arith_res     o_res
);
    import chb_pkg::*;

    logic         r_busy;
    logic [7:0]   r_cnt;
    logic [127:0] r_dvd;
    logic [63:0]  r_rem, r_q;
    logic         r_qhi, r_neg;
    logic [62:0]  r_r;
    logic [63:0]  rem_sh;
    logic         ge;
    logic [63:0]  limit;

    // remainder stays below the 63-bit radius, so the shifted value fits 64 bits
    assign rem_sh = {r_rem[62:0], r_dvd[127]};
    assign ge     = rem_sh >= {1'b0, r_r};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 8'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 8'd0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 8'd1;
            if (r_cnt == 8'd128) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_sh61 ? ({64'd0, i_mag} << 61) : ({64'd0, i_mag} << 32);
            r_rem <= '0;
            r_q   <= '0;
            r_qhi <= 1'b0;
            r_neg <= i_neg;
            r_r   <= i_r;
        end else if (r_busy && r_cnt != 8'd128) begin
            r_dvd <= {r_dvd[126:0], 1'b0};
            r_rem <= ge ? (rem_sh - {1'b0, r_r}) : rem_sh;
            r_q   <= {r_q[62:0], ge};
            r_qhi <= r_qhi | r_q[63];
        end
    end

    always_comb begin
        limit = r_neg ? SAT_MIN : SAT_MAX;
        if (r_qhi || r_q > limit) begin
            o_res.ovf   = 1'b1;
            o_res.value = limit;
        end else begin
            o_res.ovf   = 1'b0;
            o_res.value = r_neg ? (64'd0 - r_q) : r_q;
        end
        o_done = r_busy && (r_cnt == 8'd128);
    end
endmodule
`default_nettype wire

FILE: bench/chb_tb_if.sv
`timescale 1ns / 1ps
// Interfaces come from the RTL; this file holds a small shared helper package for the bench.
package chb_tb_pkg;
    localparam int BEATS_PER_PHASE = 60;
endpackage

FILE: bench/chebyshev_eval_with_derivative_tb.sv
`timescale 1ns / 1ps
module chebyshev_eval_with_derivative_tb;
    import chb_pkg::*;
    import chb_tb_pkg::*;

    typedef struct {
        logic [63:0] value;
        logic [63:0] slope;
        logic [1:0]  status;
    } t_eval_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [4:0]  i_cfg_wr_data = '0;

    chb_item_if item_bus ();
    chb_res_if  res_bus ();

    chebyshev_eval_with_derivative u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_item(item_bus),
        .o_res(res_bus)
    );

    always #5 i_clk = ~i_clk;

    logic [63:0] coef_mirror [MAX_COEFFS];
    logic [4:0]  degree_mirror;
    t_eval_res   pending_res [$];
    int          mismatch_cnt;
    int          eval_cnt;
    bit          idle_on;
    longint      cycle_cnt;

    // ---------------------------------------------------------------- predictor
    function automatic logic [63:0] sadd(logic [63:0] a, logic [63:0] b, inout bit ovf);
        logic [63:0] r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63]) begin
            ovf = 1'b1;
            return a[63] ? SAT_MIN : SAT_MAX;
        end
        return r;
    endfunction

    function automatic logic [63:0] ssub(logic [63:0] a, logic [63:0] b, inout bit ovf);
        logic [63:0] r;
        r = a - b;
        if (a[63] != b[63] && r[63] != a[63]) begin
            ovf = 1'b1;
            return a[63] ? SAT_MIN : SAT_MAX;
        end
        return r;
    endfunction

    // signed (a*b) >>> sh, round half up, saturated
    function automatic logic [63:0] mul_rnd(logic [63:0] a, logic [63:0] b, int sh,
                                           inout bit ovf);
        logic signed [127:0] p;
        logic signed [127:0] q;
        p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
        p = p + (128'sd1 <<< (sh - 1));
        q = p >>> sh;
        if (q > 128'sh7FFF_FFFF_FFFF_FFFF || q < -128'sh8000_0000_0000_0000) begin
            ovf = 1'b1;
            return q[127] ? SAT_MIN : SAT_MAX;
        end
        return q[63:0];
    endfunction

    function automatic logic [63:0] div_trunc(logic [63:0] mag, bit neg, int sh,
                                             logic [62:0] r, inout bit ovf);
        logic [127:0] q;
        q = ({64'd0, mag} << sh) / {65'd0, r};
        if (q > (neg ? {64'd0, SAT_MIN} : {64'd0, SAT_MAX})) begin
            ovf = 1'b1;
            return neg ? SAT_MIN : SAT_MAX;
        end
        return neg ? (64'd0 - q[63:0]) : q[63:0];
    endfunction

    function automatic t_eval_res predict_eval(logic [63:0] x, logic [63:0] m, logic [62:0] r);
        t_eval_res   res;
        logic [63:0] mag, s, w0, w1, w2, d0, d1, d2, val, num;
        bit          neg, ovf;
        ovf = 1'b0;
        w0 = 0; w1 = 0; w2 = 0; d0 = 0; d1 = 0; d2 = 0;
        if (r == 0) begin
            res.value = 0; res.slope = 0; res.status = STATUS_ZERO_RADIUS;
            return res;
        end
        neg = $signed(x) < $signed(m);
        mag = neg ? m - x : x - m;
        s = div_trunc(mag, neg, 61, r, ovf);
        for (int j = degree_mirror; j >= 1; j--) begin
            w2 = w1; w1 = w0;
            w0 = sadd(coef_mirror[j], ssub(mul_rnd(s, w1, 60, ovf), w2, ovf), ovf);
            d2 = d1; d1 = d0;
            d0 = ssub(sadd(sadd(w1, w1, ovf), mul_rnd(s, d1, 60, ovf), ovf), d2, ovf);
        end
        val = sadd(coef_mirror[0], ssub(mul_rnd(s, w0, 61, ovf), w1, ovf), ovf);
        num = ssub(sadd(w0, mul_rnd(s, d0, 61, ovf), ovf), d1, ovf);
        res.slope = div_trunc(mag_of(num), num[63], 32, r, ovf);
        res.value = val;
        res.status = ovf ? STATUS_OVERFLOW : STATUS_OK;
        return res;
    endfunction

    // ---------------------------------------------------------------- drivers
    task automatic idle_gap();
        if (idle_on && $urandom_range(0, 3) == 0) begin
            item_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
    endtask

    task automatic send_beat(logic fn, logic [4:0] idx, logic [63:0] cv,
                             logic [63:0] x, logic [63:0] m, logic [62:0] r);
        idle_gap();
        item_bus.valid      <= 1'b1;
        item_bus.func       <= fn;
        item_bus.coef_index <= idx;
        item_bus.coef_value <= cv;
        item_bus.time_point <= x;
        item_bus.midpoint   <= m;
        item_bus.radius     <= r;
        do @(posedge i_clk); while (!item_bus.ready);
        if (fn == FUNC_LOAD) begin
            coef_mirror[idx] = cv;
        end else begin
            pending_res.push_back(predict_eval(x, m, r));
            eval_cnt++;
        end
        // valid stays up; the next beat or an idle gap replaces it
        @(negedge i_clk);
    endtask

    task automatic load_coef(logic [4:0] idx, logic [63:0] cv);
        send_beat(FUNC_LOAD, idx, cv, 64'($urandom), 64'($urandom), 63'($urandom));
    endtask

    task automatic eval_at(logic [63:0] x, logic [63:0] m, logic [62:0] r);
        send_beat(FUNC_EVAL, 5'($urandom), {$urandom, $urandom}, x, m, r);
    endtask

    task automatic drain();
        item_bus.valid <= 1'b0;
        while (pending_res.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic set_degree(logic [4:0] d);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= d;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        degree_mirror = d;
    endtask

    function automatic logic [63:0] rand_wide();
        case ($urandom_range(0, 3))
            0: return {$urandom, $urandom};
            1: return {{32{1'b0}}, $urandom};
            2: return 64'(longint'($urandom_range(0, 2000)) - 1000) <<< 30;
            default: return $urandom_range(0, 1) ? SAT_MAX : SAT_MIN;
        endcase
    endfunction

    // coefficients small enough that most evaluations stay in range
    function automatic logic [63:0] rand_coef();
        if ($urandom_range(0, 7) == 0) return rand_wide();
        return 64'($signed($urandom)) <<< $urandom_range(0, 12);
    endfunction

    // random evaluation, mostly inside the interval
    task automatic rand_eval();
        logic [62:0] r;
        logic [63:0] m, x;
        int pick;
        pick = $urandom_range(0, 9);
        m = {$urandom_range(0, 1) ? {32{1'b1}} : 32'd0, $urandom};
        m = m <<< $urandom_range(0, 31);
        r = 63'($urandom_range(1, 'hFFFF)) << $urandom_range(0, 46);
        if (pick == 0) r = 63'({$urandom, $urandom});
        if (pick == 1) r = 0;
        if (pick < 8) x = m + 64'($signed(64'({$urandom, $urandom}) % {1'b0, r}));
        else x = {$urandom, $urandom};
        eval_at(x, m, r);
    endtask

    task automatic fill_store(int upto);
        for (int i = 0; i <= upto; i++) load_coef(i[4:0], rand_coef());
    endtask

    // ---------------------------------------------------------------- tests
    task automatic test_reset_degree();
        load_coef(0, 64'h0000_0100_0000_0000);
        eval_at(64'd5 << 32, 0, 63'd10 << 32);
        eval_at(SAT_MAX, SAT_MIN, 63'd1);
    endtask

    task automatic test_directed_extremes();
        fill_store(31);
        load_coef(31, SAT_MAX);
        load_coef(1, SAT_MIN);
        set_degree(5'd31);
        eval_at(0, 0, 63'h7FFF_FFFF_FFFF_FFFF);
        eval_at(SAT_MAX, SAT_MIN, 63'h7FFF_FFFF_FFFF_FFFF);
        eval_at(SAT_MIN, SAT_MAX, 63'd1);
        eval_at(64'd3 << 32, 64'd3 << 32, 0);
        eval_at(64'd1 << 32, 0, 63'd1 << 32);
        eval_at(-(64'd1 << 32), 0, 63'd1 << 32);
        set_degree(5'd1);
        eval_at(64'd1 << 31, 0, 63'd1 << 32);
        eval_at(64'hFFFF_FFFF_FFFF_FFFF, 0, 63'd1);
        set_degree(5'd2);
        load_coef(0, 0);
        load_coef(1, 64'd1 << 40);
        load_coef(2, 64'd1 << 40);
        eval_at(64'd7 << 30, 64'd1 << 30, 63'd3 << 32);
        eval_at({$urandom, $urandom}, {$urandom, $urandom}, 63'({$urandom, $urandom}));
    endtask

    task automatic test_random_phase(logic [4:0] d, int beats);
        set_degree(d);
        fill_store(d);
        for (int n = 0; n < beats; n++) begin
            if ($urandom_range(0, 4) == 0) load_coef(5'($urandom_range(0, d)), rand_coef());
            else rand_eval();
        end
    endtask

    // ---------------------------------------------------------------- checker
    always @(posedge i_clk) begin
        t_eval_res exp_res;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (pending_res.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result beat: value=%h slope=%h status=%0d",
                             res_bus.value, res_bus.slope, res_bus.status);
            end else begin
                exp_res = pending_res.pop_front();
                if (res_bus.value !== exp_res.value || res_bus.slope !== exp_res.slope ||
                    res_bus.status !== exp_res.status) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: exp %h %h %0d got %h %h %0d",
                                 exp_res.value, exp_res.slope, exp_res.status,
                                 res_bus.value, res_bus.slope, res_bus.status);
                end
            end
        end
    end

    // random backpressure in bursts, none once idle_on drops
    always @(negedge i_clk) begin
        if (idle_on && res_bus.ready && $urandom_range(0, 5) == 0) begin
            res_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            res_bus.ready <= 1'b1;
        end else begin
            res_bus.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > 2_000_000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        item_bus.valid = 1'b0;
        item_bus.func = FUNC_LOAD;
        item_bus.coef_index = '0;
        item_bus.coef_value = '0;
        item_bus.time_point = '0;
        item_bus.midpoint = '0;
        item_bus.radius = '0;
        res_bus.ready = 1'b1;
        mismatch_cnt = 0;
        eval_cnt = 0;
        cycle_cnt = 0;
        degree_mirror = 0;
        idle_on = 1'b1;
        foreach (coef_mirror[i]) coef_mirror[i] = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_degree();
        test_directed_extremes();
        test_random_phase(5'd0, 40);
        test_random_phase(5'd3, 120);
        test_random_phase(5'd8, 100);
        test_random_phase(5'd31, 30);
        idle_on = 1'b0;
        test_random_phase(5'd4, BEATS_PER_PHASE);
        drain();

        if (mismatch_cnt == 0 && pending_res.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
